[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the look-at view matrix RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LAV_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LAV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/lav_pkg.sv]
// ----------------------------------------------------------------------------
// lav_pkg
// Types and constants of the look-at view matrix block.
// ----------------------------------------------------------------------------
package lav_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int XW            = 32;
   localparam int WW            = 17;

   localparam logic [1:0] ROW_RIGHT = 2'd0;
   localparam logic [1:0] ROW_UP    = 2'd1;
   localparam logic [1:0] ROW_BACK  = 2'd2;
   localparam logic [1:0] ROW_TRANS = 2'd3;

   typedef struct packed {
      logic signed [XW-1:0] eye_x;
      logic signed [XW-1:0] eye_y;
      logic signed [XW-1:0] eye_z;
      logic signed [XW-1:0] aim_x;
      logic signed [XW-1:0] aim_y;
      logic signed [XW-1:0] aim_z;
      logic signed [XW-1:0] up_x;
      logic signed [XW-1:0] up_y;
      logic signed [XW-1:0] up_z;
   } req_type;

   typedef struct packed {
      logic [1:0]           row_index;
      logic signed [XW-1:0] col0;
      logic signed [XW-1:0] col1;
      logic signed [XW-1:0] col2;
      logic [WW-1:0]        col3;
      logic                 degenerate;
      logic                 last_row;
   } rsp_type;

endpackage

[rtl/look_at_view_matrix.sv]
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Builds a look-at view matrix from eye, target and up, emitted as four rows.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | beat
//  req     | in        | req_valid/req_stall| eye, aim, up (lav_pkg::req_type)
//  rsp     | out       | rsp_valid/rsp_stall| one matrix row (lav_pkg::rsp_type)
//
// One beat in gives four beats out, rows 0..3; the single result port sets the
// sustained rate, and new requests are taken while earlier ones are in flight.
// The path from accept to row 0 runs through three normalizers, each a 31-step
// square root and a FRAC_BITS+1 step divider.
// Synchronous reset clears all valid bits; the pipeline holds as a whole when
// a finished matrix waits at the tail, the row buffer is full and its last row
// is not taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module look_at_view_matrix #(
   parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lav_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lav_pkg::rsp_type rsp_data
);

   localparam int F   = FRAC_BITS;
   localparam int XW  = lav_pkg::XW;
   localparam int OW  = F + 2;
   localparam int PW1 = OW + XW;
   localparam int CW1 = OW + XW + 1;
   localparam int PW2 = 2 * OW;
   localparam int CW2 = 2 * OW + 1;
   localparam int DW  = OW + XW;
   localparam int SDW = OW + XW + 2;
   localparam int SW1 = 6 * XW;
   localparam int SW2 = 3 * XW + 3 * OW + 1;
   localparam int SW3 = 3 * XW + 6 * OW + 2;
   localparam logic [lav_pkg::WW-1:0] W_ONE = lav_pkg::WW'(64'(1) << F);
   localparam logic signed [SDW-1:0] SAT_HI = SDW'(64'sh7FFF_FFFF);
   localparam logic signed [SDW-1:0] SAT_LO = -SAT_HI - SDW'(1);
   localparam logic signed [SDW-1:0] HALF   = SDW'(64'(1) << (F - 1));

   logic en;
   logic load;
   logic load_ok;
   logic rsp_accept;

   // input and difference stages
   logic                 a_v_ff;
   lav_pkg::req_type     a_ff;
   logic                 b_v_ff;
   logic signed [XW:0]   diff_ff [3];
   logic [SW1-1:0]       b_side_ff;

   // normalizer 1
   logic                 n1_v;
   logic signed [OW-1:0] n1_x, n1_y, n1_z;
   logic                 n1_zero;
   logic [SW1-1:0]       n1_side;
   logic signed [OW-1:0] dv [3];
   logic signed [XW-1:0] upv [3];

   // first cross product
   logic                 c1_v_ff;
   logic signed [PW1-1:0] c1_p_ff [6];
   logic [SW2-1:0]       c1_side_ff;
   logic                 c2_v_ff;
   logic signed [CW1-1:0] c2_c_ff [3];
   logic [SW2-1:0]       c2_side_ff;

   // normalizer 2
   logic                 n2_v;
   logic signed [OW-1:0] n2_x, n2_y, n2_z;
   logic                 n2_zero;
   logic [SW2-1:0]       n2_side;
   logic signed [OW-1:0] d2v [3];
   logic signed [OW-1:0] rv [3];

   // second cross product
   logic                 c3_v_ff;
   logic signed [PW2-1:0] c3_p_ff [6];
   logic [SW3-1:0]       c3_side_ff;
   logic                 c4_v_ff;
   logic signed [CW2-1:0] c4_c_ff [3];
   logic [SW3-1:0]       c4_side_ff;

   // normalizer 3
   logic                 n3_v;
   logic signed [OW-1:0] n3_x, n3_y, n3_z;
   logic                 n3_zero;
   logic [SW3-1:0]       n3_side;
   logic signed [XW-1:0] eye3 [3];
   logic signed [OW-1:0] d3v [3];
   logic signed [OW-1:0] r3v [3];
   logic signed [OW-1:0] u3v [3];

   // translation dot products
   logic                 d1_v_ff;
   logic signed [DW-1:0] d1_p_ff [3][3];
   logic signed [OW-1:0] d1_axis_ff [3][3];
   logic                 d1_deg_ff;
   logic                 d2_v_ff;
   logic signed [SDW-1:0] d2_s_ff [3];
   logic signed [OW-1:0] d2_axis_ff [3][3];
   logic                 d2_deg_ff;
   logic                 d3_v_ff;
   logic signed [XW-1:0] d3_rows_ff [4][3];
   logic                 d3_deg_ff;

   // row buffer
   logic                 ob_valid_ff;
   logic [1:0]           ob_row_ff;
   logic signed [XW-1:0] ob_rows_ff [4][3];
   logic                 ob_deg_ff;

   assign rsp_accept = rsp_valid && !rsp_stall;
   assign load_ok    = !ob_valid_ff || (rsp_accept && ob_row_ff == lav_pkg::ROW_TRANS);
   assign load       = d3_v_ff && load_ok;
   assign en         = !d3_v_ff || load_ok;
   assign req_stall  = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff  <= 1'b0;
         b_v_ff  <= 1'b0;
         c1_v_ff <= 1'b0;
         c2_v_ff <= 1'b0;
         c3_v_ff <= 1'b0;
         c4_v_ff <= 1'b0;
         d1_v_ff <= 1'b0;
         d2_v_ff <= 1'b0;
         d3_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff  <= req_valid;
         b_v_ff  <= a_v_ff;
         c1_v_ff <= n1_v;
         c2_v_ff <= c1_v_ff;
         c3_v_ff <= n2_v;
         c4_v_ff <= c3_v_ff;
         d1_v_ff <= n3_v;
         d2_v_ff <= d1_v_ff;
         d3_v_ff <= d2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff       <= req_data;
         diff_ff[0] <= (XW+1)'(a_ff.aim_x) - (XW+1)'(a_ff.eye_x);
         diff_ff[1] <= (XW+1)'(a_ff.aim_y) - (XW+1)'(a_ff.eye_y);
         diff_ff[2] <= (XW+1)'(a_ff.aim_z) - (XW+1)'(a_ff.eye_z);
         b_side_ff  <= {a_ff.eye_x, a_ff.eye_y, a_ff.eye_z,
                        a_ff.up_x, a_ff.up_y, a_ff.up_z};
      end
   end

   lav_norm #(.IW(XW + 1), .F(F), .SW(SW1)) u_norm_dir (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(b_v_ff),
      .in_x(diff_ff[0]), .in_y(diff_ff[1]), .in_z(diff_ff[2]),
      .in_side(b_side_ff),
      .out_valid(n1_v),
      .out_x(n1_x), .out_y(n1_y), .out_z(n1_z),
      .out_zero(n1_zero),
      .out_side(n1_side)
   );

   assign dv[0]  = n1_x;
   assign dv[1]  = n1_y;
   assign dv[2]  = n1_z;
   assign upv[0] = n1_side[3*XW-1:2*XW];
   assign upv[1] = n1_side[2*XW-1:XW];
   assign upv[2] = n1_side[XW-1:0];

   // right axis = d x up
   always_ff @(posedge clock) begin
      if (en) begin
         c1_p_ff[0] <= PW1'(dv[1]) * PW1'(upv[2]);
         c1_p_ff[1] <= PW1'(dv[2]) * PW1'(upv[1]);
         c1_p_ff[2] <= PW1'(dv[2]) * PW1'(upv[0]);
         c1_p_ff[3] <= PW1'(dv[0]) * PW1'(upv[2]);
         c1_p_ff[4] <= PW1'(dv[0]) * PW1'(upv[1]);
         c1_p_ff[5] <= PW1'(dv[1]) * PW1'(upv[0]);
         c1_side_ff <= {n1_side[SW1-1:3*XW], dv[0], dv[1], dv[2], n1_zero};

         c2_c_ff[0] <= CW1'(c1_p_ff[0]) - CW1'(c1_p_ff[1]);
         c2_c_ff[1] <= CW1'(c1_p_ff[2]) - CW1'(c1_p_ff[3]);
         c2_c_ff[2] <= CW1'(c1_p_ff[4]) - CW1'(c1_p_ff[5]);
         c2_side_ff <= c1_side_ff;
      end
   end

   lav_norm #(.IW(CW1), .F(F), .SW(SW2)) u_norm_right (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(c2_v_ff),
      .in_x(c2_c_ff[0]), .in_y(c2_c_ff[1]), .in_z(c2_c_ff[2]),
      .in_side(c2_side_ff),
      .out_valid(n2_v),
      .out_x(n2_x), .out_y(n2_y), .out_z(n2_z),
      .out_zero(n2_zero),
      .out_side(n2_side)
   );

   assign rv[0]  = n2_x;
   assign rv[1]  = n2_y;
   assign rv[2]  = n2_z;
   assign d2v[0] = n2_side[3*OW:2*OW+1];
   assign d2v[1] = n2_side[2*OW:OW+1];
   assign d2v[2] = n2_side[OW:1];

   // true up axis = r x d
   always_ff @(posedge clock) begin
      if (en) begin
         c3_p_ff[0] <= PW2'(rv[1]) * PW2'(d2v[2]);
         c3_p_ff[1] <= PW2'(rv[2]) * PW2'(d2v[1]);
         c3_p_ff[2] <= PW2'(rv[2]) * PW2'(d2v[0]);
         c3_p_ff[3] <= PW2'(rv[0]) * PW2'(d2v[2]);
         c3_p_ff[4] <= PW2'(rv[0]) * PW2'(d2v[1]);
         c3_p_ff[5] <= PW2'(rv[1]) * PW2'(d2v[0]);
         c3_side_ff <= {n2_side[SW2-1:1], rv[0], rv[1], rv[2], n2_side[0], n2_zero};

         c4_c_ff[0] <= CW2'(c3_p_ff[0]) - CW2'(c3_p_ff[1]);
         c4_c_ff[1] <= CW2'(c3_p_ff[2]) - CW2'(c3_p_ff[3]);
         c4_c_ff[2] <= CW2'(c3_p_ff[4]) - CW2'(c3_p_ff[5]);
         c4_side_ff <= c3_side_ff;
      end
   end

   lav_norm #(.IW(CW2), .F(F), .SW(SW3)) u_norm_up (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(c4_v_ff),
      .in_x(c4_c_ff[0]), .in_y(c4_c_ff[1]), .in_z(c4_c_ff[2]),
      .in_side(c4_side_ff),
      .out_valid(n3_v),
      .out_x(n3_x), .out_y(n3_y), .out_z(n3_z),
      .out_zero(n3_zero),
      .out_side(n3_side)
   );

   assign u3v[0]  = n3_x;
   assign u3v[1]  = n3_y;
   assign u3v[2]  = n3_z;
   assign eye3[0] = n3_side[SW3-1:SW3-XW];
   assign eye3[1] = n3_side[SW3-XW-1:SW3-2*XW];
   assign eye3[2] = n3_side[SW3-2*XW-1:SW3-3*XW];
   assign d3v[0]  = n3_side[6*OW+1:5*OW+2];
   assign d3v[1]  = n3_side[5*OW+1:4*OW+2];
   assign d3v[2]  = n3_side[4*OW+1:3*OW+2];
   assign r3v[0]  = n3_side[3*OW+1:2*OW+2];
   assign r3v[1]  = n3_side[2*OW+1:OW+2];
   assign r3v[2]  = n3_side[OW+1:2];

   // translation row: -(r.eye), -(u.eye), d.eye, round half up, saturate
   always_ff @(posedge clock) begin
      logic signed [SDW-1:0] sh;
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            d1_p_ff[0][i]    <= DW'(r3v[i]) * DW'(eye3[i]);
            d1_p_ff[1][i]    <= DW'(u3v[i]) * DW'(eye3[i]);
            d1_p_ff[2][i]    <= DW'(d3v[i]) * DW'(eye3[i]);
            d1_axis_ff[0][i] <= r3v[i];
            d1_axis_ff[1][i] <= u3v[i];
            d1_axis_ff[2][i] <= d3v[i];
         end
         d1_deg_ff <= n3_zero | n3_side[1] | n3_side[0];

         d2_s_ff[0] <= -(SDW'(d1_p_ff[0][0]) + SDW'(d1_p_ff[0][1]) + SDW'(d1_p_ff[0][2]));
         d2_s_ff[1] <= -(SDW'(d1_p_ff[1][0]) + SDW'(d1_p_ff[1][1]) + SDW'(d1_p_ff[1][2]));
         d2_s_ff[2] <= SDW'(d1_p_ff[2][0]) + SDW'(d1_p_ff[2][1]) + SDW'(d1_p_ff[2][2]);
         d2_axis_ff <= d1_axis_ff;
         d2_deg_ff  <= d1_deg_ff;

         for (int i = 0; i < 3; i++) begin
            sh = (d2_s_ff[i] + HALF) >>> F;
            if (sh > SAT_HI) begin
               d3_rows_ff[3][i] <= XW'(SAT_HI);
            end else if (sh < SAT_LO) begin
               d3_rows_ff[3][i] <= XW'(SAT_LO);
            end else begin
               d3_rows_ff[3][i] <= XW'(sh);
            end
            d3_rows_ff[0][i] <= XW'(d2_axis_ff[0][i]);
            d3_rows_ff[1][i] <= XW'(d2_axis_ff[1][i]);
            d3_rows_ff[2][i] <= -XW'(d2_axis_ff[2][i]);
         end
         d3_deg_ff <= d2_deg_ff;
      end
   end

   // row buffer: hold one matrix, advance a row per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         ob_valid_ff <= 1'b0;
         ob_row_ff   <= lav_pkg::ROW_RIGHT;
      end else if (load) begin
         ob_valid_ff <= 1'b1;
         ob_row_ff   <= lav_pkg::ROW_RIGHT;
      end else if (rsp_accept) begin
         if (ob_row_ff == lav_pkg::ROW_TRANS) begin
            ob_valid_ff <= 1'b0;
         end
         ob_row_ff <= ob_row_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ob_rows_ff <= d3_rows_ff;
         ob_deg_ff  <= d3_deg_ff;
      end
   end

   always_comb begin
      rsp_data            = '0;
      rsp_data.row_index  = ob_row_ff;
      rsp_data.col0       = ob_rows_ff[ob_row_ff][0];
      rsp_data.col1       = ob_rows_ff[ob_row_ff][1];
      rsp_data.col2       = ob_rows_ff[ob_row_ff][2];
      rsp_data.col3       = (ob_row_ff == lav_pkg::ROW_TRANS) ? W_ONE : '0;
      rsp_data.degenerate = ob_deg_ff;
      rsp_data.last_row   = (ob_row_ff == lav_pkg::ROW_TRANS);
   end

   assign rsp_valid = ob_valid_ff;

   `LAV_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, d3_v_ff && ob_valid_ff, "stall without full tail")
   `LAV_ASSERT_NEXT(a_row_step, clock, reset, rsp_valid && !rsp_stall && !rsp_data.last_row, rsp_valid && (rsp_data.row_index == 2'($past(rsp_data.row_index) + 2'd1)), "row did not advance")
   `LAV_ASSERT_NEXT(a_drain, clock, reset, rsp_valid && !rsp_stall && rsp_data.last_row && !d3_v_ff, !rsp_valid, "buffer did not drain")

endmodule

[rtl/lav_norm.sv]
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: scale to 30 bits, digit-by-digit square
// root, then restoring division per lane, one step per stage.
// ----------------------------------------------------------------------------
module lav_norm #(
   parameter int IW = 33,
   parameter int F  = 16,
   parameter int SW = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [IW-1:0] in_x,
   input  logic signed [IW-1:0] in_y,
   input  logic signed [IW-1:0] in_z,
   input  logic [SW-1:0]        in_side,
   output logic                 out_valid,
   output logic signed [F+1:0]  out_x,
   output logic signed [F+1:0]  out_y,
   output logic signed [F+1:0]  out_z,
   output logic                 out_zero,
   output logic [SW-1:0]        out_side
);

   localparam int G        = (IW + 7) / 8;
   localparam int GW       = $clog2(G);
   localparam int BW       = $clog2(IW + 1);
   localparam int SQ_STEPS = 31;
   localparam int SQW      = 63;
   localparam int NW       = 31 + F;
   localparam int QW       = F + 1;
   localparam int OW       = F + 2;

   logic signed [IW-1:0] vin [3];
   assign vin[0] = in_x;
   assign vin[1] = in_y;
   assign vin[2] = in_z;

   // stage 1: sign and magnitude
   logic              v1_ff;
   logic [2:0]        neg1_ff;
   logic [IW-1:0]     mag1_ff [3];
   logic [SW-1:0]     side1_ff;

   // stage 2: combined bit pattern for the leading-one search
   logic              v2_ff;
   logic [2:0]        neg2_ff;
   logic [IW-1:0]     mag2_ff [3];
   logic [G*8-1:0]    orp2_ff;
   logic [SW-1:0]     side2_ff;

   // stage 3: top nonzero byte
   logic              v3_ff;
   logic [2:0]        neg3_ff;
   logic [IW-1:0]     mag3_ff [3];
   logic [GW-1:0]     gsel3_ff;
   logic [7:0]        gbyte3_ff;
   logic              zero3_ff;
   logic [SW-1:0]     side3_ff;
   logic [GW-1:0]     gsel_in;
   logic [7:0]        gbyte_in;

   // stage 4: bit length
   logic              v4_ff;
   logic [2:0]        neg4_ff;
   logic [IW-1:0]     mag4_ff [3];
   logic [BW-1:0]     b4_ff;
   logic              zero4_ff;
   logic [SW-1:0]     side4_ff;
   logic [2:0]        pos_in;

   // stage 5: scaled magnitudes
   logic              v5_ff;
   logic [2:0]        neg5_ff;
   logic [29:0]       sm5_ff [3];
   logic              zero5_ff;
   logic [SW-1:0]     side5_ff;

   // stage 6: squares
   logic              v6_ff;
   logic [2:0]        neg6_ff;
   logic [29:0]       sm6_ff [3];
   logic [59:0]       sq6_ff [3];
   logic              zero6_ff;
   logic [SW-1:0]     side6_ff;

   // square root steps
   logic              sv_ff    [0:SQ_STEPS];
   logic [SQW-1:0]    sn_ff    [0:SQ_STEPS];
   logic [SQW-1:0]    sr_ff    [0:SQ_STEPS];
   logic [29:0]       ssm_ff   [0:SQ_STEPS][3];
   logic [2:0]        sneg_ff  [0:SQ_STEPS];
   logic              szero_ff [0:SQ_STEPS];
   logic [SW-1:0]     sside_ff [0:SQ_STEPS];

   // division steps
   logic              dv_ff    [0:QW];
   logic [NW-1:0]     dn_ff    [0:QW][3];
   logic [QW-1:0]     dq_ff    [0:QW][3];
   logic [30:0]       dd_ff    [0:QW];
   logic [2:0]        dneg_ff  [0:QW];
   logic              dzero_ff [0:QW];
   logic [SW-1:0]     dside_ff [0:QW];

   logic              ov_ff;
   logic signed [OW-1:0] o_ff [3];
   logic              ozero_ff;
   logic [SW-1:0]     oside_ff;

   always_comb begin
      gsel_in  = '0;
      gbyte_in = '0;
      for (int g = 0; g < G; g++) begin
         if (orp2_ff[g*8 +: 8] != 8'd0) begin
            gsel_in  = GW'(g);
            gbyte_in = orp2_ff[g*8 +: 8];
         end
      end
   end

   always_comb begin
      pos_in = '0;
      for (int p = 0; p < 8; p++) begin
         if (gbyte3_ff[p]) pos_in = 3'(p);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         ov_ff <= 1'b0;
         for (int j = 0; j <= SQ_STEPS; j++) sv_ff[j] <= 1'b0;
         for (int j = 0; j <= QW; j++) dv_ff[j] <= 1'b0;
      end else if (en) begin
         v1_ff    <= in_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         v6_ff    <= v5_ff;
         sv_ff[0] <= v6_ff;
         for (int j = 1; j <= SQ_STEPS; j++) sv_ff[j] <= sv_ff[j-1];
         dv_ff[0] <= sv_ff[SQ_STEPS];
         for (int j = 1; j <= QW; j++) dv_ff[j] <= dv_ff[j-1];
         ov_ff    <= dv_ff[QW];
      end
   end

   // front stages
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            neg1_ff[i] <= vin[i][IW-1];
            mag1_ff[i] <= vin[i][IW-1] ? unsigned'(-vin[i]) : unsigned'(vin[i]);
         end
         side1_ff <= in_side;

         neg2_ff  <= neg1_ff;
         mag2_ff  <= mag1_ff;
         orp2_ff  <= (G*8)'(mag1_ff[0] | mag1_ff[1] | mag1_ff[2]);
         side2_ff <= side1_ff;

         neg3_ff   <= neg2_ff;
         mag3_ff   <= mag2_ff;
         gsel3_ff  <= gsel_in;
         gbyte3_ff <= gbyte_in;
         zero3_ff  <= (orp2_ff == '0);
         side3_ff  <= side2_ff;

         neg4_ff  <= neg3_ff;
         mag4_ff  <= mag3_ff;
         b4_ff    <= BW'({gsel3_ff, 3'b000}) + BW'(pos_in) + BW'(1);
         zero4_ff <= zero3_ff;
         side4_ff <= side3_ff;

         // bring the largest magnitude into [2^29, 2^30)
         for (int i = 0; i < 3; i++) begin
            sm5_ff[i] <= 30'({mag4_ff[i], 30'd0} >> b4_ff);
         end
         neg5_ff  <= neg4_ff;
         zero5_ff <= zero4_ff;
         side5_ff <= side4_ff;

         for (int i = 0; i < 3; i++) begin
            sq6_ff[i] <= 60'(sm5_ff[i]) * 60'(sm5_ff[i]);
         end
         sm6_ff   <= sm5_ff;
         neg6_ff  <= neg5_ff;
         zero6_ff <= zero5_ff;
         side6_ff <= side5_ff;
      end
   end

   // square root, one result bit per stage
   always_ff @(posedge clock) begin
      logic [SQW-1:0] bitv;
      logic [SQW-1:0] t;
      if (en) begin
         sn_ff[0]    <= SQW'(sq6_ff[0]) + SQW'(sq6_ff[1]) + SQW'(sq6_ff[2]);
         sr_ff[0]    <= '0;
         ssm_ff[0]   <= sm6_ff;
         sneg_ff[0]  <= neg6_ff;
         szero_ff[0] <= zero6_ff;
         sside_ff[0] <= side6_ff;
         for (int j = 1; j <= SQ_STEPS; j++) begin
            bitv = SQW'(1) << (2 * (SQ_STEPS - j));
            t    = sr_ff[j-1] + bitv;
            if (sn_ff[j-1] >= t) begin
               sn_ff[j] <= sn_ff[j-1] - t;
               sr_ff[j] <= (sr_ff[j-1] >> 1) + bitv;
            end else begin
               sn_ff[j] <= sn_ff[j-1];
               sr_ff[j] <= sr_ff[j-1] >> 1;
            end
            ssm_ff[j]   <= ssm_ff[j-1];
            sneg_ff[j]  <= sneg_ff[j-1];
            szero_ff[j] <= szero_ff[j-1];
            sside_ff[j] <= sside_ff[j-1];
         end
      end
   end

   // rounded division by the length, one quotient bit per stage
   always_ff @(posedge clock) begin
      logic [30:0]   len;
      logic [NW-1:0] sub;
      if (en) begin
         len = sr_ff[SQ_STEPS][30:0];
         for (int l = 0; l < 3; l++) begin
            dn_ff[0][l] <= NW'({ssm_ff[SQ_STEPS][l], {F{1'b0}}}) + NW'(len >> 1);
            dq_ff[0][l] <= '0;
         end
         dd_ff[0]    <= len;
         dneg_ff[0]  <= sneg_ff[SQ_STEPS];
         dzero_ff[0] <= szero_ff[SQ_STEPS];
         dside_ff[0] <= sside_ff[SQ_STEPS];
         for (int j = 1; j <= QW; j++) begin
            sub = NW'(dd_ff[j-1]) << (QW - j);
            for (int l = 0; l < 3; l++) begin
               if (dn_ff[j-1][l] >= sub) begin
                  dn_ff[j][l] <= dn_ff[j-1][l] - sub;
                  dq_ff[j][l] <= dq_ff[j-1][l] | (QW'(1) << (QW - j));
               end else begin
                  dn_ff[j][l] <= dn_ff[j-1][l];
                  dq_ff[j][l] <= dq_ff[j-1][l];
               end
            end
            dd_ff[j]    <= dd_ff[j-1];
            dneg_ff[j]  <= dneg_ff[j-1];
            dzero_ff[j] <= dzero_ff[j-1];
            dside_ff[j] <= dside_ff[j-1];
         end

         // reapply signs, drop to zero on a zero-length vector
         for (int l = 0; l < 3; l++) begin
            if (dzero_ff[QW]) begin
               o_ff[l] <= '0;
            end else if (dneg_ff[QW][l]) begin
               o_ff[l] <= -signed'(OW'(dq_ff[QW][l]));
            end else begin
               o_ff[l] <= signed'(OW'(dq_ff[QW][l]));
            end
         end
         ozero_ff <= dzero_ff[QW];
         oside_ff <= dside_ff[QW];
      end
   end

   assign out_valid = ov_ff;
   assign out_x     = o_ff[0];
   assign out_y     = o_ff[1];
   assign out_z     = o_ff[2];
   assign out_zero  = ozero_ff;
   assign out_side  = oside_ff;

endmodule
